>>> design/rdbs_pkg.sv
// ---------------------------------------------------------------------------
// rdbs_pkg
// Types and constants shared by the roi depth back-projection statistics block.
// ---------------------------------------------------------------------------
package rdbs_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int DEPTH_LIMIT_MM = 1000;

	localparam int JOBQ_AW    = 2;
	localparam int JOBQ_DEPTH = 1 << JOBQ_AW;

	localparam logic [20:0] COUNT_FULL = 21'h1FFFFF;
	localparam logic signed [23:0] XY_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] XY_MIN = -24'sh800000;

	localparam logic [2:0] REG_ROI_LEFT    = 3'd0;
	localparam logic [2:0] REG_ROI_TOP     = 3'd1;
	localparam logic [2:0] REG_ROI_WIDTH   = 3'd2;
	localparam logic [2:0] REG_ROI_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_PRINCIPAL_X = 3'd4;
	localparam logic [2:0] REG_PRINCIPAL_Y = 3'd5;
	localparam logic [2:0] REG_FOCAL_X     = 3'd6;
	localparam logic [2:0] REG_FOCAL_Y     = 3'd7;

	typedef struct packed {
		logic [15:0] depth_mm;
		logic [9:0]  pixel_col;
		logic [9:0]  pixel_row;
		logic        frame_end;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [20:0]        kept_count;
		logic signed [23:0] mean_x_mm;
		logic signed [23:0] mean_y_mm;
		logic [9:0]         mean_z_mm;
		logic [23:0]        extent_x_mm;
		logic [23:0]        extent_y_mm;
		logic [9:0]         extent_z_mm;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  roi_left;
		logic [9:0]  roi_top;
		logic [9:0]  roi_width;
		logic [9:0]  roi_height;
		logic [13:0] principal_x;
		logic [13:0] principal_y;
		logic [15:0] focal_x;
		logic [15:0] focal_y;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic               keep;
		logic               last;
		logic signed [25:0] dx;
		logic signed [25:0] dy;
		logic [9:0]         z;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PX,
		ST_PY,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_EMIT
	} back_state_t;

endpackage

>>> design/rdbs_div.sv
// ---------------------------------------------------------------------------
// rdbs_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module rdbs_div import rdbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] num,
	input  logic [20:0]        den,
	output logic               done,
	output logic signed [47:0] quo
);

	logic [47:0] n_q;
	logic [47:0] q_q;
	logic [21:0] r_q;
	logic [20:0] d_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [21:0] r_sh;
	logic [21:0] r_sub;

	assign r_sh  = {r_q[20:0], n_q[47]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[47] ? 48'(-num) : num;
			neg_q <= num[47];
			d_q   <= den;
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[46:0], 1'b0};
			if (!r_sub[21]) begin
				r_q <= r_sub;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

>>> design/rdbs_front.sv
// ---------------------------------------------------------------------------
// rdbs_front
// Accepts pixels, applies rectangle and depth tests, forms offsets, queues jobs.
// ---------------------------------------------------------------------------
module rdbs_front import rdbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     push,
	output logic     full,
	input  in_item_t data_in,
	output logic     job_valid,
	input  logic     job_take,
	output job_t     job
);

	job_t               fifo_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wp_q;
	logic [JOBQ_AW-1:0] rp_q;
	logic [JOBQ_AW:0]   cnt_q;
	job_t       nj;
	logic       in_roi;
	logic [10:0] right;
	logic [10:0] bottom;
	logic       wr;
	logic       rd;

	assign right  = {1'b0, cfg.roi_left} + {1'b0, cfg.roi_width};
	assign bottom = {1'b0, cfg.roi_top} + {1'b0, cfg.roi_height};

	always_comb begin
		in_roi = (data_in.pixel_col >= cfg.roi_left) && ({1'b0, data_in.pixel_col} <= right)
			&& (data_in.pixel_row >= cfg.roi_top) && ({1'b0, data_in.pixel_row} <= bottom)
			&& (32'(data_in.pixel_col) < MAX_WIDTH) && (32'(data_in.pixel_row) < MAX_HEIGHT);
		nj.keep = in_roi && (data_in.depth_mm != 16'd0)
			&& (32'(data_in.depth_mm) <= DEPTH_LIMIT_MM);
		nj.last = data_in.frame_end;
		nj.dx   = $signed({12'b0, data_in.pixel_col, 4'b0}) - $signed({12'b0, cfg.principal_x});
		nj.dy   = $signed({12'b0, data_in.pixel_row, 4'b0}) - $signed({12'b0, cfg.principal_y});
		nj.z    = data_in.depth_mm[9:0];
	end

	assign full      = (cnt_q == (JOBQ_AW + 1)'(JOBQ_DEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = fifo_q[rp_q];
	assign wr        = push && !full;
	assign rd        = job_take && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + JOBQ_AW'(1);
			if (rd) rp_q <= rp_q + JOBQ_AW'(1);
			cnt_q <= cnt_q + (JOBQ_AW + 1)'(wr) - (JOBQ_AW + 1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) fifo_q[wp_q] <= nj;
	end

endmodule

>>> design/rdbs_back.sv
// ---------------------------------------------------------------------------
// rdbs_back
// Back-projects kept pixels, accumulates statistics and forms frame results.
// ---------------------------------------------------------------------------
module rdbs_back import rdbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	output logic      job_take,
	input  job_t      job,
	output logic      empty,
	input  logic      pop,
	output out_item_t data_out
);

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [20:0] kept_q;
	logic signed [47:0] sum_x_q, sum_y_q;
	logic [30:0] sum_z_q;
	logic signed [23:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [9:0]  min_z_q, max_z_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        dstart;
	logic signed [47:0] dnum;
	logic [20:0] dden;
	logic        ddone;
	logic signed [47:0] dquo;
	logic signed [41:0] prod_q;
	logic signed [23:0] sat;
	logic [15:0] fx, fy;

	assign fx = (cfg.focal_x == 16'd0) ? 16'd1 : cfg.focal_x;
	assign fy = (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;

	rdbs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	always_comb begin
		if (dquo > 48'(XY_MAX)) sat = XY_MAX;
		else if (dquo < 48'(XY_MIN)) sat = XY_MIN;
		else sat = dquo[23:0];
	end

	function automatic logic kept_q_ok();
		return !((state_q == ST_MX || state_q == ST_MY || state_q == ST_MZ) && kept_q == 21'd0);
	endfunction

	// a frame's last pixel waits in the queue while a result is pending
	always_comb begin
		state_d  = state_q;
		job_take = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid && (!out_valid_q || !job.last)) begin
					job_take = 1'b1;
					if (job.keep && kept_q != COUNT_FULL) state_d = ST_PX;
					else if (job.last) state_d = ST_MX;
				end
			end
			ST_PX: if (ddone) state_d = ST_PY;
			ST_PY: if (ddone) state_d = job_q.last ? ST_MX : ST_IDLE;
			ST_MX: if (ddone || kept_q == 21'd0) state_d = ST_MY;
			ST_MY: if (ddone || kept_q == 21'd0) state_d = ST_MZ;
			ST_MZ: if (ddone || kept_q == 21'd0) state_d = ST_EMIT;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// divider launches in the cycle a dividing state is entered, when its product is already registered
	logic launch_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
			kept_q      <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			min_x_q     <= XY_MAX;
			max_x_q     <= XY_MIN;
			min_y_q     <= XY_MAX;
			max_y_q     <= XY_MIN;
			min_z_q     <= 10'(DEPTH_LIMIT_MM);
			max_z_q     <= '0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q) && (state_d != ST_IDLE) && (state_d != ST_EMIT);
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			if (state_q == ST_PX && ddone) begin
				if (sat < min_x_q) min_x_q <= sat;
				if (sat > max_x_q) max_x_q <= sat;
				sum_x_q <= sum_x_q + 48'(sat);
			end
			if (state_q == ST_PY && ddone) begin
				if (sat < min_y_q) min_y_q <= sat;
				if (sat > max_y_q) max_y_q <= sat;
				sum_y_q <= sum_y_q + 48'(sat);
				sum_z_q <= sum_z_q + 31'(job_q.z);
				kept_q  <= kept_q + 21'd1;
				if (job_q.z < min_z_q) min_z_q <= job_q.z;
				if (job_q.z > max_z_q) max_z_q <= job_q.z;
			end
			if (state_q == ST_EMIT) begin
				out_valid_q <= 1'b1;
				kept_q  <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				min_x_q <= XY_MAX;
				max_x_q <= XY_MIN;
				min_y_q <= XY_MAX;
				max_y_q <= XY_MIN;
				min_z_q <= 10'(DEPTH_LIMIT_MM);
				max_z_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) job_q <= job;
		unique case (state_d)
			ST_PX:   prod_q <= 42'(job.dx * $signed({1'b0, job.z}));
			ST_PY:   prod_q <= 42'(job_q.dy * $signed({1'b0, job_q.z}));
			default: prod_q <= prod_q;
		endcase
		if (state_q == ST_MX && (ddone || kept_q == 21'd0)) out_q.mean_x_mm <= dquo[23:0];
		if (state_q == ST_MY && (ddone || kept_q == 21'd0)) out_q.mean_y_mm <= dquo[23:0];
		if (state_q == ST_MZ && (ddone || kept_q == 21'd0)) out_q.mean_z_mm <= dquo[9:0];
		if (state_q == ST_EMIT) begin
			out_q.found      <= kept_q != 21'd0;
			out_q.kept_count <= kept_q;
			if (kept_q == 21'd0) begin
				out_q.mean_x_mm <= '0;
				out_q.mean_y_mm <= '0;
				out_q.mean_z_mm <= '0;
			end
			out_q.extent_x_mm <= (kept_q == 21'd0) ? 24'd0 : 24'(max_x_q - min_x_q);
			out_q.extent_y_mm <= (kept_q == 21'd0) ? 24'd0 : 24'(max_y_q - min_y_q);
			out_q.extent_z_mm <= (kept_q == 21'd0) ? 10'd0 : max_z_q - min_z_q;
		end
	end

	always_comb begin
		dstart = launch_q && kept_q_ok();
		dden   = {5'b0, fx};
		dnum   = 48'(prod_q);
		unique case (state_q)
			ST_PY:   dden = {5'b0, fy};
			ST_MX:   begin dden = kept_q; dnum = sum_x_q; end
			ST_MY:   begin dden = kept_q; dnum = sum_y_q; end
			ST_MZ:   begin dden = kept_q; dnum = 48'({17'b0, sum_z_q}); end
			default: dden = {5'b0, fx};
		endcase
	end

	assign empty    = !out_valid_q;
	assign data_out = out_q;

endmodule

>>> design/roi_depth_backproject_stats.sv
// ---------------------------------------------------------------------------
// roi_depth_backproject_stats
// Region-of-interest depth statistics with pinhole back-projection.
// ---------------------------------------------------------------------------
// input: push a pixel while full is low; a short queue decouples intake
// from the statistics engine, so pixels are taken at once until it fills.
// each kept pixel makes two passes through the shared 48-step divider
// (X then Y); a dropped pixel is taken without a division.
// frame_end adds three mean divisions (none when nothing was kept), then
// the result appears while empty is low and holds until popped. while a
// result waits, pixels of the next frame are still processed, but its last
// pixel holds at the queue head, so a stalled receiver backs up into full.
// reset clears statistics and sets focal lengths to 16, other registers 0.
// configuration is an apb slave, register i at byte 4*i, pready always high.
// ---------------------------------------------------------------------------
module roi_depth_backproject_stats import rdbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    data_in,
	output logic        empty,
	input  logic        pop,
	output out_item_t   data_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	logic job_valid, job_take;
	job_t job;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {68'd0, 16'd16, 16'd16};
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ROI_LEFT:    cfg_q.roi_left    <= pwdata[9:0];
				REG_ROI_TOP:     cfg_q.roi_top     <= pwdata[9:0];
				REG_ROI_WIDTH:   cfg_q.roi_width   <= pwdata[9:0];
				REG_ROI_HEIGHT:  cfg_q.roi_height  <= pwdata[9:0];
				REG_PRINCIPAL_X: cfg_q.principal_x <= pwdata[13:0];
				REG_PRINCIPAL_Y: cfg_q.principal_y <= pwdata[13:0];
				REG_FOCAL_X:     cfg_q.focal_x     <= pwdata[15:0];
				REG_FOCAL_Y:     cfg_q.focal_y     <= pwdata[15:0];
				default:         cfg_q.roi_left    <= cfg_q.roi_left;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROI_LEFT:    prdata = {22'b0, cfg_q.roi_left};
			REG_ROI_TOP:     prdata = {22'b0, cfg_q.roi_top};
			REG_ROI_WIDTH:   prdata = {22'b0, cfg_q.roi_width};
			REG_ROI_HEIGHT:  prdata = {22'b0, cfg_q.roi_height};
			REG_PRINCIPAL_X: prdata = {18'b0, cfg_q.principal_x};
			REG_PRINCIPAL_Y: prdata = {18'b0, cfg_q.principal_y};
			REG_FOCAL_X:     prdata = {16'b0, cfg_q.focal_x};
			REG_FOCAL_Y:     prdata = {16'b0, cfg_q.focal_y};
			default:         prdata = '0;
		endcase
	end

	rdbs_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .push(push), .full(full),
		.data_in(data_in), .job_valid(job_valid), .job_take(job_take), .job(job)
	);

	rdbs_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .job_valid(job_valid),
		.job_take(job_take), .job(job), .empty(empty), .pop(pop), .data_out(data_out)
	);

endmodule

>>> design/rdbs_checker.sv
// ---------------------------------------------------------------------------
// rdbs_checker
// Port-level checks on the result channel of the statistics block.
// ---------------------------------------------------------------------------
module rdbs_checker import rdbs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t data_out
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(data_out)) else $error("result changed");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> data_out.found == (data_out.kept_count != 21'd0)) else $error("found flag");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !data_out.found |-> data_out.extent_x_mm == 24'd0
		&& data_out.mean_z_mm == 10'd0) else $error("empty frame not zero");

	a_z: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> data_out.extent_z_mm <= 10'd1000) else $error("z extent range");

endmodule

bind roi_depth_backproject_stats rdbs_checker u_rdbs_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .data_out(data_out)
);
